/* rtl/core/hkrt_pkg.sv */
`timescale 1ns / 1ps
package hkrt_pkg;

   localparam int BOOT_KEY_SLOTS      = 6;
   localparam int CONSUMER_SLOT_COUNT = 30;

   localparam int KEY_CODE_FIRST      = 1;
   localparam int KEY_CODE_LAST       = 256;
   localparam int CONSUMER_CODE_FIRST = 257;
   localparam int CONSUMER_CODE_END   = 1280;
   localparam int CONSUMER_USAGE_BASE = 256;
   localparam int MOD_FIRST           = 224;
   localparam int BITMAP_ROWS         = 32;
   localparam int BOOT_KEY_FIELDS     = 6;

   localparam int CODE_W  = 11;
   localparam int USAGE_W = 10;
   localparam int SLOT_W  = 5;

   typedef struct packed {
      logic [CODE_W-1:0] key_code;
      logic              pressed;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         modifiers;
      logic [7:0]         boot_key_0;
      logic [7:0]         boot_key_1;
      logic [7:0]         boot_key_2;
      logic [7:0]         boot_key_3;
      logic [7:0]         boot_key_4;
      logic [7:0]         boot_key_5;
      logic               boot_changed;
      logic               consumer_changed;
      logic [SLOT_W-1:0]  consumer_slot;
      logic [USAGE_W-1:0] consumer_value;
   } rsp_payload_type;

endpackage

/* rtl/core/hkrt_stream_if.sv */
`timescale 1ns / 1ps
interface hkrt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/hid_keyboard_report_tracker.sv */
`timescale 1ns / 1ps
// HID boot keyboard report tracker with a consumer-key slot table.
// req_stream carries key events (key_code, pressed); rsp_stream returns one
// report transaction per event: the boot report (modifier mask and the first
// pressed keycodes below 224 in ascending order), a boot change flag and the
// consumer slot written by the event, if any.
// Key state lives in a 32 x 8 bitmap RAM, consumer usages in a slot RAM; both
// have a registered read port and are walked one entry per cycle.
// One event is handled at a time. Steps from accept to result valid:
//   keyboard code, bitmap changed : read-modify-write, then a rebuild walk
//                                   over bitmap rows 0..28
//   keyboard code, no change      : bitmap read and compare only
//   consumer code                 : slot walk, then a slot write if needed
//   ignored code                  : straight to the result register
// req_stream.ready is high only while no event is in flight, so the next
// event is taken only after the result of the last one is loaded.
// Reset (synchronous, active high) marks all bitmap rows and slots as empty
// and clears the report; no clearing pass is needed.
// The result sits in an output register; while rsp_stream stalls the block
// finishes the next event and holds it until the register frees up.
module hid_keyboard_report_tracker #(
   parameter int BOOT_KEY_SLOTS      = hkrt_pkg::BOOT_KEY_SLOTS,
   parameter int CONSUMER_SLOT_COUNT = hkrt_pkg::CONSUMER_SLOT_COUNT
) (
   input logic           clock,
   input logic           reset,
   hkrt_stream_if.sink   req_stream,
   hkrt_stream_if.source rsp_stream
);

   localparam int SLOT_IW  = (CONSUMER_SLOT_COUNT > 1) ? $clog2(CONSUMER_SLOT_COUNT) : 1;
   localparam int SLOT_CW  = $clog2(CONSUMER_SLOT_COUNT + 1);
   localparam int KEY_IW   = (BOOT_KEY_SLOTS > 1) ? $clog2(BOOT_KEY_SLOTS) : 1;
   localparam int KEY_NW   = $clog2(BOOT_KEY_SLOTS + 1);
   localparam int ROW_W    = $clog2(hkrt_pkg::BITMAP_ROWS);
   localparam int MOD_ROW  = hkrt_pkg::MOD_FIRST / 8;
   localparam int CODE_W   = hkrt_pkg::CODE_W;
   localparam int USAGE_W  = hkrt_pkg::USAGE_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_KEY_WR   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_CON_SCAN = 3'd3;
   localparam logic [2:0] S_CON_WR   = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [CODE_W-1:0]        code_ff, code_in;
   logic                     press_ff, press_in;
   logic                     boot_chg_ff, boot_chg_in;
   logic                     cons_chg_ff, cons_chg_in;
   logic [SLOT_IW-1:0]       cslot_ff, cslot_in;
   logic [USAGE_W-1:0]       cval_ff, cval_in;

   logic [7:0]               mods_ff, mods_in;
   logic [7:0]               keys_ff [BOOT_KEY_SLOTS];
   logic [7:0]               keys_in [BOOT_KEY_SLOTS];
   logic [KEY_NW-1:0]        key_cnt_ff, key_cnt_in;

   logic [ROW_W-1:0]         scan_ff, scan_in;
   logic                     proc_vld_ff, proc_vld_in;
   logic [ROW_W-1:0]         proc_row_ff, proc_row_in;

   logic [SLOT_CW-1:0]       cidx_ff, cidx_in;
   logic                     cproc_vld_ff, cproc_vld_in;
   logic [SLOT_IW-1:0]       cproc_idx_ff, cproc_idx_in;
   logic                     match_found_ff, match_found_in;
   logic [SLOT_IW-1:0]       match_idx_ff, match_idx_in;
   logic                     free_found_ff, free_found_in;
   logic [SLOT_IW-1:0]       free_idx_ff, free_idx_in;

   hkrt_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // bitmap RAM
   logic [7:0]                        bitmap_mem [hkrt_pkg::BITMAP_ROWS];
   logic [hkrt_pkg::BITMAP_ROWS-1:0]  row_valid_ff;
   logic [7:0]                        bitmap_rd_ff;
   logic                              bitmap_hit_ff;
   logic [ROW_W-1:0]                  bm_rd_addr;
   logic                              bm_we;
   logic [ROW_W-1:0]                  bm_wr_row;
   logic [7:0]                        bm_wr_data;
   logic [7:0]                        bm_byte;

   // consumer slot RAM
   logic [USAGE_W-1:0]                slot_mem [CONSUMER_SLOT_COUNT];
   logic [CONSUMER_SLOT_COUNT-1:0]    slot_valid_ff;
   logic [USAGE_W-1:0]                slot_rd_ff;
   logic                              slot_hit_ff;
   logic [SLOT_IW-1:0]                slot_rd_addr;
   logic                              slot_we;
   logic [SLOT_IW-1:0]                slot_wr_idx;
   logic [USAGE_W-1:0]                slot_wr_data;
   logic [USAGE_W-1:0]                slot_val;

   logic                req_take;
   logic                req_is_key;
   logic                req_is_con;
   logic [7:0]          req_kc;
   logic [7:0]          cur_kc;
   logic [USAGE_W-1:0]  usage;
   logic [7:0]          new_byte;
   logic                scan_issue;
   logic                rsp_load;
   logic [7:0]          boot_out [hkrt_pkg::BOOT_KEY_FIELDS];

   assign req_stream.ready = (state_ff == S_IDLE);
   assign req_take         = req_stream.valid && req_stream.ready;
   assign req_is_key       = req_stream.payload.key_code inside
      {[CODE_W'(hkrt_pkg::KEY_CODE_FIRST):CODE_W'(hkrt_pkg::KEY_CODE_LAST)]};
   assign req_is_con       = req_stream.payload.key_code inside
      {[CODE_W'(hkrt_pkg::CONSUMER_CODE_FIRST):CODE_W'(hkrt_pkg::CONSUMER_CODE_END - 1)]};
   assign req_kc           = 8'(req_stream.payload.key_code - CODE_W'(1));
   assign cur_kc           = 8'(code_ff - CODE_W'(1));
   assign usage            = USAGE_W'(code_ff - CODE_W'(hkrt_pkg::CONSUMER_USAGE_BASE));
   assign bm_byte          = bitmap_hit_ff ? bitmap_rd_ff : 8'd0;
   assign slot_val         = slot_hit_ff ? slot_rd_ff : '0;
   assign scan_issue       = (state_ff == S_SCAN) && (scan_ff <= ROW_W'(MOD_ROW));

   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_ff;

   generate
      for (genvar k = 0; k < hkrt_pkg::BOOT_KEY_FIELDS; k++) begin : g_boot
         if (k < BOOT_KEY_SLOTS) begin : g_used
            assign boot_out[k] = keys_ff[k];
         end else begin : g_zero
            assign boot_out[k] = 8'd0;
         end
      end
   endgenerate

   always_comb begin
      new_byte = bm_byte;
      new_byte[cur_kc[2:0]] = press_ff;
   end

   always_comb begin
      bm_rd_addr   = (state_ff == S_IDLE) ? req_kc[7:3] : scan_ff;
      slot_rd_addr = (state_ff == S_IDLE) ? '0 : cidx_ff[SLOT_IW-1:0];
   end

   always_comb begin
      logic [KEY_NW-1:0] cnt;

      cnt            = key_cnt_ff;
      state_in       = state_ff;
      code_in        = code_ff;
      press_in       = press_ff;
      boot_chg_in    = boot_chg_ff;
      cons_chg_in    = cons_chg_ff;
      cslot_in       = cslot_ff;
      cval_in        = cval_ff;
      mods_in        = mods_ff;
      keys_in        = keys_ff;
      key_cnt_in     = key_cnt_ff;
      scan_in        = scan_ff;
      proc_vld_in    = scan_issue;
      proc_row_in    = scan_ff;
      cidx_in        = cidx_ff;
      cproc_vld_in   = 1'b0;
      cproc_idx_in   = slot_rd_addr;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      bm_we          = 1'b0;
      bm_wr_row      = cur_kc[7:3];
      bm_wr_data     = new_byte;
      slot_we        = 1'b0;
      slot_wr_idx    = free_idx_ff;
      slot_wr_data   = usage;
      rsp_load       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               code_in        = req_stream.payload.key_code;
               press_in       = req_stream.payload.pressed;
               boot_chg_in    = 1'b0;
               cons_chg_in    = 1'b0;
               cslot_in       = '0;
               cval_in        = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               cidx_in        = SLOT_CW'(1);
               if (req_is_key) begin
                  state_in = S_KEY_WR;
               end else if (req_is_con) begin
                  cproc_vld_in = 1'b1;
                  state_in     = S_CON_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_KEY_WR: begin
            if (bm_byte[cur_kc[2:0]] != press_ff) begin
               bm_we       = 1'b1;
               boot_chg_in = 1'b1;
               scan_in     = '0;
               mods_in     = 8'd0;
               key_cnt_in  = '0;
               for (int k = 0; k < BOOT_KEY_SLOTS; k++) begin
                  keys_in[k] = 8'd0;
               end
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (scan_issue) begin
               scan_in = scan_ff + ROW_W'(1);
            end
            if (proc_vld_ff) begin
               if (proc_row_ff == ROW_W'(MOD_ROW)) begin
                  mods_in  = bm_byte;
                  state_in = S_DONE;
               end else begin
                  for (int b = 0; b < 8; b++) begin
                     if (bm_byte[b] && (cnt < KEY_NW'(BOOT_KEY_SLOTS))) begin
                        keys_in[cnt[KEY_IW-1:0]] = {proc_row_ff, 3'(b)};
                        cnt = cnt + KEY_NW'(1);
                     end
                  end
                  key_cnt_in = cnt;
               end
            end
         end
         S_CON_SCAN: begin
            if (cidx_ff < SLOT_CW'(CONSUMER_SLOT_COUNT)) begin
               cproc_vld_in = 1'b1;
               cidx_in      = cidx_ff + SLOT_CW'(1);
            end
            if (cproc_vld_ff) begin
               if ((slot_val == usage) && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = cproc_idx_ff;
               end
               if ((slot_val == '0) && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cproc_idx_ff;
               end
               if (cproc_idx_ff == SLOT_IW'(CONSUMER_SLOT_COUNT - 1)) begin
                  state_in = S_CON_WR;
               end
            end
         end
         S_CON_WR: begin
            if (press_ff) begin
               if (!match_found_ff && free_found_ff) begin
                  slot_we      = 1'b1;
                  slot_wr_idx  = free_idx_ff;
                  slot_wr_data = usage;
                  cons_chg_in  = 1'b1;
                  cslot_in     = free_idx_ff;
                  cval_in      = usage;
               end
            end else if (match_found_ff) begin
               slot_we      = 1'b1;
               slot_wr_idx  = match_idx_ff;
               slot_wr_data = '0;
               cons_chg_in  = 1'b1;
               cslot_in     = match_idx_ff;
               cval_in      = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_stream.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in                  = rsp_ff;
      rsp_in.modifiers        = mods_ff;
      rsp_in.boot_key_0       = boot_out[0];
      rsp_in.boot_key_1       = boot_out[1];
      rsp_in.boot_key_2       = boot_out[2];
      rsp_in.boot_key_3       = boot_out[3];
      rsp_in.boot_key_4       = boot_out[4];
      rsp_in.boot_key_5       = boot_out[5];
      rsp_in.boot_changed     = boot_chg_ff;
      rsp_in.consumer_changed = cons_chg_ff;
      rsp_in.consumer_slot    = hkrt_pkg::SLOT_W'(cslot_ff);
      rsp_in.consumer_value   = cval_ff;
      rsp_valid_in            = rsp_load || (rsp_valid_ff && !rsp_stream.ready);
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_wr_row] <= bm_wr_data;
      end
      bitmap_rd_ff  <= bitmap_mem[bm_rd_addr];
      bitmap_hit_ff <= row_valid_ff[bm_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wr_idx] <= slot_wr_data;
      end
      slot_rd_ff  <= slot_mem[slot_rd_addr];
      slot_hit_ff <= slot_valid_ff[slot_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         row_valid_ff  <= '0;
         slot_valid_ff <= '0;
         mods_ff       <= 8'd0;
         key_cnt_ff    <= '0;
         for (int k = 0; k < BOOT_KEY_SLOTS; k++) begin
            keys_ff[k] <= 8'd0;
         end
         proc_vld_ff   <= 1'b0;
         cproc_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (bm_we) begin
            row_valid_ff[bm_wr_row] <= 1'b1;
         end
         if (slot_we) begin
            slot_valid_ff[slot_wr_idx] <= 1'b1;
         end
         mods_ff      <= mods_in;
         key_cnt_ff   <= key_cnt_in;
         keys_ff      <= keys_in;
         proc_vld_ff  <= proc_vld_in;
         cproc_vld_ff <= cproc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      press_ff       <= press_in;
      boot_chg_ff    <= boot_chg_in;
      cons_chg_ff    <= cons_chg_in;
      cslot_ff       <= cslot_in;
      cval_ff        <= cval_in;
      scan_ff        <= scan_in;
      proc_row_ff    <= proc_row_in;
      cidx_ff        <= cidx_in;
      cproc_idx_ff   <= cproc_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* test/hid_keyboard_report_tracker_test.sv */
`timescale 1ns / 1ps
module hid_keyboard_report_tracker_test;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   hkrt_stream_if #(.payload_type(hkrt_pkg::req_payload_type)) req_if ();
   hkrt_stream_if #(.payload_type(hkrt_pkg::rsp_payload_type)) rsp_if ();

   hid_keyboard_report_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   bit [255:0]                   key_map;
   logic [hkrt_pkg::USAGE_W-1:0] consumer_table [hkrt_pkg::CONSUMER_SLOT_COUNT];
   hkrt_pkg::rsp_payload_type    expected_reports [$];

   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;

   // Tracks the key bitmap and consumer table, returns the report for one event.
   function automatic hkrt_pkg::rsp_payload_type predict_report(
      input logic [hkrt_pkg::CODE_W-1:0] code, input logic pressed);
      hkrt_pkg::rsp_payload_type    r;
      logic [7:0]                   keys [hkrt_pkg::BOOT_KEY_FIELDS];
      logic [hkrt_pkg::USAGE_W-1:0] usage;
      bit                           found;
      int                           n;
      int                           kc;
      r = '0;
      found = 1'b0;
      n = 0;
      if (code >= hkrt_pkg::KEY_CODE_FIRST && code <= hkrt_pkg::KEY_CODE_LAST) begin
         kc = int'(code) - 1;
         if (key_map[kc] != pressed) begin
            key_map[kc] = pressed;
            r.boot_changed = 1'b1;
         end
      end else if (code >= hkrt_pkg::CONSUMER_CODE_FIRST &&
                   code < hkrt_pkg::CONSUMER_CODE_END) begin
         usage = hkrt_pkg::USAGE_W'(int'(code) - hkrt_pkg::CONSUMER_USAGE_BASE);
         foreach (consumer_table[i])
            if (consumer_table[i] == usage) found = 1'b1;
         if (pressed && !found) begin
            for (int i = 0; i < hkrt_pkg::CONSUMER_SLOT_COUNT; i++) begin
               if (consumer_table[i] == '0) begin
                  consumer_table[i] = usage;
                  r.consumer_changed = 1'b1;
                  r.consumer_slot = hkrt_pkg::SLOT_W'(i);
                  r.consumer_value = usage;
                  break;
               end
            end
         end else if (!pressed) begin
            for (int i = 0; i < hkrt_pkg::CONSUMER_SLOT_COUNT; i++) begin
               if (consumer_table[i] == usage) begin
                  consumer_table[i] = '0;
                  r.consumer_changed = 1'b1;
                  r.consumer_slot = hkrt_pkg::SLOT_W'(i);
                  break;
               end
            end
         end
      end
      foreach (keys[i]) keys[i] = '0;
      for (int k = 0; k < hkrt_pkg::MOD_FIRST; k++) begin
         if (key_map[k] && n < hkrt_pkg::BOOT_KEY_FIELDS) begin
            keys[n] = 8'(k);
            n++;
         end
      end
      r.modifiers  = key_map[hkrt_pkg::MOD_FIRST +: 8];
      r.boot_key_0 = keys[0];
      r.boot_key_1 = keys[1];
      r.boot_key_2 = keys[2];
      r.boot_key_3 = keys[3];
      r.boot_key_4 = keys[4];
      r.boot_key_5 = keys[5];
      return r;
   endfunction

   task automatic send_key_event(input logic [hkrt_pkg::CODE_W-1:0] code,
                                 input logic pressed);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= hkrt_pkg::req_payload_type'{key_code: code, pressed: pressed};
      do @(posedge clock); while (!req_if.ready);
      expected_reports.push_back(predict_report(code, pressed));
   endtask

   task automatic wait_for_reports();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   function automatic void random_key_event(output logic [hkrt_pkg::CODE_W-1:0] code,
                                            output logic pressed);
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         case ($urandom_range(3))
            0: begin
               code = hkrt_pkg::CODE_W'($urandom_range(1, 16));
            end
            1: begin
               code = hkrt_pkg::CODE_W'($urandom_range(217, 232));
            end
            2: begin
               code = hkrt_pkg::CODE_W'($urandom_range(1, 256));
            end
            default: begin
               code = hkrt_pkg::CODE_W'($urandom_range(233, 256));
            end
         endcase
         pressed = ($urandom_range(99) < 60);
      end else if (pick < 75) begin
         code = hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_USAGE_BASE + $urandom_range(1, 40));
         pressed = ($urandom_range(99) < 55);
      end else if (pick < 88) begin
         code = hkrt_pkg::CODE_W'($urandom_range(hkrt_pkg::CONSUMER_CODE_FIRST,
                                                 hkrt_pkg::CONSUMER_CODE_END - 1));
         pressed = 1'($urandom_range(1));
      end else begin
         code = ($urandom_range(3) == 0) ? '0
                : hkrt_pkg::CODE_W'($urandom_range(hkrt_pkg::CONSUMER_CODE_END, 2047));
         pressed = 1'($urandom_range(1));
      end
   endfunction

   task automatic test_ignored_codes();
      send_key_event('0, 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_CODE_END), 1'b1);
      send_key_event('1, 1'b0);
   endtask

   task automatic test_keyboard_extremes();
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::KEY_CODE_FIRST), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::KEY_CODE_FIRST), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::KEY_CODE_LAST), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::KEY_CODE_LAST), 1'b0);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::KEY_CODE_LAST), 1'b0);
      // modifier range ends
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::MOD_FIRST + 1), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::MOD_FIRST + 8), 1'b1);
   endtask

   task automatic test_boot_overflow();
      send_key_event(hkrt_pkg::CODE_W'(3), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(5), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(7), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(9), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(11), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::MOD_FIRST), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::KEY_CODE_FIRST), 1'b0);
   endtask

   task automatic test_consumer_basic();
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_CODE_END - 1), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_CODE_FIRST), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_CODE_FIRST), 1'b1);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_CODE_END - 1), 1'b0);
      send_key_event(hkrt_pkg::CODE_W'(hkrt_pkg::CONSUMER_CODE_END - 1), 1'b0);
   endtask

   task automatic test_consumer_table_full();
      logic [hkrt_pkg::USAGE_W-1:0] held [$];
      logic [hkrt_pkg::USAGE_W-1:0] usage;
      int used;
      int drops;
      drops = 0;
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      while (drops < 3) begin
         used = 0;
         foreach (consumer_table[i])
            if (consumer_table[i] != '0) used++;
         if (used == hkrt_pkg::CONSUMER_SLOT_COUNT) drops++;
         usage = hkrt_pkg::USAGE_W'($urandom_range(1, 1023));
         held.push_back(usage);
         send_key_event(hkrt_pkg::CODE_W'(usage + hkrt_pkg::CONSUMER_USAGE_BASE), 1'b1);
      end
      held.shuffle();
      foreach (held[i])
         send_key_event(hkrt_pkg::CODE_W'(held[i] + hkrt_pkg::CONSUMER_USAGE_BASE), 1'b0);
      wait_for_reports();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      logic [hkrt_pkg::CODE_W-1:0] code;
      logic                        pressed;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         random_key_event(code, pressed);
         send_key_event(code, pressed);
      end
      wait_for_reports();
   endtask

   // long receiver hold while the sender keeps offering
   task automatic test_output_backpressure();
      logic [hkrt_pkg::CODE_W-1:0] code;
      logic                        pressed;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 300;
      repeat (12) begin
         random_key_event(code, pressed);
         send_key_event(code, pressed);
      end
      wait_for_reports();
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : report_check
      hkrt_pkg::rsp_payload_type want;
      hkrt_pkg::rsp_payload_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_reports.size() == 0) begin
            error_count++;
            $error("report transaction with no event pending");
         end else begin
            want = expected_reports.pop_front();
            compare_field("modifiers", 16'(want.modifiers), 16'(got.modifiers));
            compare_field("boot_key_0", 16'(want.boot_key_0), 16'(got.boot_key_0));
            compare_field("boot_key_1", 16'(want.boot_key_1), 16'(got.boot_key_1));
            compare_field("boot_key_2", 16'(want.boot_key_2), 16'(got.boot_key_2));
            compare_field("boot_key_3", 16'(want.boot_key_3), 16'(got.boot_key_3));
            compare_field("boot_key_4", 16'(want.boot_key_4), 16'(got.boot_key_4));
            compare_field("boot_key_5", 16'(want.boot_key_5), 16'(got.boot_key_5));
            compare_field("boot_changed", 16'(want.boot_changed), 16'(got.boot_changed));
            compare_field("consumer_changed", 16'(want.consumer_changed),
                          16'(got.consumer_changed));
            compare_field("consumer_slot", 16'(want.consumer_slot),
                          16'(got.consumer_slot));
            compare_field("consumer_value", 16'(want.consumer_value),
                          16'(got.consumer_value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      key_map = '0;
      foreach (consumer_table[i]) consumer_table[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_codes();
      test_keyboard_extremes();
      test_boot_overflow();
      test_consumer_basic();
      wait_for_reports();
      test_consumer_table_full();
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 59, 0);
      test_output_backpressure();
      test_random_traffic(100, 0, 59);
      test_random_traffic(100, 10, 10);

      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         error_count++;
         $error("%0d report transactions never arrived", expected_reports.size());
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
